// ===== rtl/hsc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsc_pkg - heading steering controller shared definitions
// Fixed-point formats, field widths, register indexes and stream item layouts.
// ----------------------------------------------------------------------------
package hsc_pkg;

	// fixed-point formats
	localparam int ANGLE_FRAC_BITS = 13;   // angle fraction bits, 8..20
	localparam int INTEGRAL_WIDTH  = 24;   // error accumulator width, 16..40

	// pi in Q32, rounded to the angle format
	localparam longint unsigned PI_Q32 = 64'd13493037705;
	localparam longint PI_Q = longint'((PI_Q32 + (64'd1 << (31 - ANGLE_FRAC_BITS)))
		>> (32 - ANGLE_FRAC_BITS));
	localparam longint TWO_PI_Q = 2 * PI_Q;

	// field widths
	localparam int HEADING_W = 16;
	localparam int STEER_W   = 8;
	localparam int DUTY_W    = 12;
	localparam int GAIN_W    = 16;
	localparam int LIMIT_W   = 23;
	localparam int MOUNT_W   = 8;
	localparam int MAXS_W    = 7;
	localparam int TOL_W     = 15;
	localparam int SERVO_W   = 10;
	localparam int DRIVE_W   = 9;
	localparam int ERR_W     = HEADING_W + 1;
	localparam int DERIV_W   = ERR_W + 1;

	// configuration port
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = LIMIT_W;

	localparam logic [CFG_INDEX_W-1:0] REG_MOVEMENT_MODE   = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_GAIN_P          = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_GAIN_I          = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_GAIN_D          = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_INTEGRAL_LIMIT  = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_MOUNT_ANGLE     = 3'd5;
	localparam logic [CFG_INDEX_W-1:0] REG_MAX_STEER       = 3'd6;
	localparam logic [CFG_INDEX_W-1:0] REG_ANGLE_TOLERANCE = 3'd7;

	// movement modes
	localparam logic MODE_PID  = 1'b0;
	localparam logic MODE_TURN = 1'b1;

	// stream layouts, last field in the lowest bits
	localparam int IN_TDATA_W  = 56;
	localparam int OUT_TDATA_W = 48;

	typedef struct packed {
		logic [2:0]                  pad;
		logic                        stop_request;
		logic signed [DUTY_W-1:0]    duty_offset;
		logic signed [STEER_W-1:0]   turn_steer;
		logic signed [HEADING_W-1:0] target_heading;
		logic signed [HEADING_W-1:0] heading;
	} in_item_t;

	typedef struct packed {
		logic [4:0]                pad;
		logic signed [DUTY_W-1:0]  right_duty;
		logic signed [DUTY_W-1:0]  left_duty;
		logic [DRIVE_W-1:0]        drive_angle;
		logic signed [SERVO_W-1:0] servo_cmd;
	} out_item_t;

endpackage

// ===== rtl/heading_steering_controller_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// heading_steering_controller_unit - PID / bang-bang heading steering
// Wraps the heading error, runs a clamped-integral PID loop or a bang-bang
// turn, and streams servo angle, drive angle and wheel duty offsets.
// ----------------------------------------------------------------------------
//
// channel   direction  handshake          payload
// s_*       in         s_tvalid/s_tready  heading, target, turn steer, duty, stop
// m_*       out        m_tvalid/m_tready  servo, drive, left/right duty; tlast=done
// cfg_*     in         cfg_we             register index, write data
//
// one transaction per cycle while m_tready stays high; a result passes from its
// input transaction through the input register, error/integral/multiply stage and output register
// the state update (error wrap, integral clamp) and the three gain multipliers
// sit in the middle stage, the correction sum and saturation ahead of the output
// reset clears the pipeline, the controller state and loads register defaults
// a stall on m_tready backs up stage by stage; the state moves only when an
// item leaves the input register
// once a done item has left the input register, later transactions are taken and dropped
//
module heading_steering_controller_unit (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// heading[15:0], target_heading[31:16], turn_steer[39:32],
	// duty_offset[51:40], stop_request[52], zero pad
	input  logic [hsc_pkg::IN_TDATA_W-1:0]     s_tdata,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// servo_cmd[9:0], drive_angle[18:10], left_duty[30:19],
	// right_duty[42:31], zero pad
	output logic [hsc_pkg::OUT_TDATA_W-1:0]    m_tdata,
	output logic                               m_tlast,   // done_res
	input  logic                               cfg_we,
	input  logic [hsc_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [hsc_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import hsc_pkg::*;

	// derived widths
	localparam int WRAP_W   = (ANGLE_FRAC_BITS + 4 > ERR_W + 1) ? ANGLE_FRAC_BITS + 4 : ERR_W + 1;
	localparam int ES_W     = INTEGRAL_WIDTH;
	localparam int CMP_A    = (ES_W > ERR_W) ? ES_W : ERR_W;
	localparam int CMP_W    = ((CMP_A > LIMIT_W) ? CMP_A : LIMIT_W) + 1;
	localparam int PROD_P_W = GAIN_W + 1 + ERR_W;
	localparam int PROD_D_W = GAIN_W + 1 + DERIV_W;
	localparam int PROD_I_W = GAIN_W + 1 + ES_W;
	localparam int CORR_W   = ((PROD_I_W > PROD_D_W) ? PROD_I_W : PROD_D_W) + 2;
	localparam int RS       = ANGLE_FRAC_BITS + 8;
	localparam int RND_W    = CORR_W - RS;
	localparam int SV_W     = (RND_W + 2 > 12) ? RND_W + 2 : 12;
	localparam int TSV_W    = MOUNT_W + 3;

	localparam logic signed [WRAP_W-1:0] PI_W     = WRAP_W'(PI_Q);
	localparam logic signed [WRAP_W-1:0] TWO_PI_W = WRAP_W'(TWO_PI_Q);
	localparam logic signed [CMP_W-1:0]  SUM_MAX  = CMP_W'((longint'(1) << (ES_W - 1)) - 1);
	localparam logic signed [CORR_W-1:0] RND_HALF = CORR_W'(longint'(1) << (RS - 1));
	localparam logic signed [SV_W-1:0]   SERVO_MIN = -SV_W'(longint'(1) << (SERVO_W - 1));
	localparam logic signed [SV_W-1:0]   SERVO_MAX = SV_W'((longint'(1) << (SERVO_W - 1)) - 1);
	localparam logic signed [SV_W-1:0]   DRIVE_MAX = SV_W'((longint'(1) << DRIVE_W) - 1);

	// configuration registers
	logic                movement_mode_q;
	logic [GAIN_W-1:0]   gain_p_q, gain_i_q, gain_d_q;
	logic [LIMIT_W-1:0]  integral_limit_q;
	logic [MOUNT_W-1:0]  mount_angle_q;
	logic [MAXS_W-1:0]   max_steer_q;
	logic [TOL_W-1:0]    angle_tolerance_q;

	// controller state
	logic signed [ES_W-1:0]  error_sum_q;
	logic signed [ERR_W-1:0] previous_error_q;
	logic                    finished_q;

	// stage 1: input register
	logic      valid_s1;
	in_item_t  item_s1;

	// stage 2: products and turn/duty results
	logic                        valid_s2;
	logic                        mode_s2;
	logic signed [PROD_P_W-1:0]  prod_p_s2;
	logic signed [PROD_D_W-1:0]  prod_d_s2;
	logic signed [PROD_I_W-1:0]  prod_i_s2;
	logic signed [TSV_W-1:0]     turn_servo_s2;
	logic signed [DUTY_W-1:0]    left_s2, right_s2;
	logic                        done_s2;

	// output register
	logic       out_valid_q;
	out_item_t  out_item_q;
	logic       out_done_q;

	// stage advance
	logic go1, go2, step1;
	assign go2      = !out_valid_q || m_tready;
	assign go1      = !valid_s2 || go2;
	assign s_tready = !valid_s1 || go1;
	assign step1    = valid_s1 && go1 && !finished_q;

	// ---------------------------------------------------------------- config
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			movement_mode_q   <= MODE_PID;
			gain_p_q          <= '0;
			gain_i_q          <= '0;
			gain_d_q          <= '0;
			integral_limit_q  <= LIMIT_W'(8388607);
			mount_angle_q     <= MOUNT_W'(90);
			max_steer_q       <= MAXS_W'(30);
			angle_tolerance_q <= TOL_W'(410);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MOVEMENT_MODE:   movement_mode_q   <= cfg_data[0];
				REG_GAIN_P:          gain_p_q          <= cfg_data[GAIN_W-1:0];
				REG_GAIN_I:          gain_i_q          <= cfg_data[GAIN_W-1:0];
				REG_GAIN_D:          gain_d_q          <= cfg_data[GAIN_W-1:0];
				REG_INTEGRAL_LIMIT:  integral_limit_q  <= cfg_data[LIMIT_W-1:0];
				REG_MOUNT_ANGLE:     mount_angle_q     <= cfg_data[MOUNT_W-1:0];
				REG_MAX_STEER:       max_steer_q       <= cfg_data[MAXS_W-1:0];
				REG_ANGLE_TOLERANCE: angle_tolerance_q <= cfg_data[TOL_W-1:0];
				default: ;
			endcase
		end
	end

	// ---------------------------------------------------------------- stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1 <= in_item_t'(s_tdata);
		end
	end

	// error wrapped once into plus or minus pi
	logic signed [WRAP_W-1:0] diff_w, wrap_w;
	logic signed [ERR_W-1:0]  err;
	assign diff_w = WRAP_W'(item_s1.target_heading) - WRAP_W'(item_s1.heading);
	always_comb begin
		if (diff_w > PI_W) begin
			wrap_w = diff_w - TWO_PI_W;
		end else if (diff_w < -PI_W) begin
			wrap_w = diff_w + TWO_PI_W;
		end else begin
			wrap_w = diff_w;
		end
	end
	assign err = wrap_w[ERR_W-1:0];

	// integral with magnitude clamp
	logic signed [CMP_W-1:0] trial, trial_abs, limit_ext, limit_eff;
	logic signed [ES_W-1:0]  error_sum_nxt;
	logic signed [DERIV_W-1:0] deriv;
	assign trial     = CMP_W'(error_sum_q) + CMP_W'(err);
	assign trial_abs = (trial < 0) ? -trial : trial;
	assign limit_ext = CMP_W'($signed({1'b0, integral_limit_q}));
	assign limit_eff = (limit_ext > SUM_MAX) ? SUM_MAX : limit_ext;
	always_comb begin
		if (trial_abs < limit_eff) begin
			error_sum_nxt = trial[ES_W-1:0];
		end else if (trial < 0) begin
			error_sum_nxt = ES_W'(-limit_eff);
		end else begin
			error_sum_nxt = limit_eff[ES_W-1:0];
		end
	end
	assign deriv = DERIV_W'(err) - DERIV_W'(previous_error_q);

	// gain products, gains are unsigned
	logic signed [PROD_P_W-1:0] prod_p;
	logic signed [PROD_D_W-1:0] prod_d;
	logic signed [PROD_I_W-1:0] prod_i;
	assign prod_p = PROD_P_W'($signed({1'b0, gain_p_q})) * PROD_P_W'(err);
	assign prod_d = PROD_D_W'($signed({1'b0, gain_d_q})) * PROD_D_W'(deriv);
	assign prod_i = PROD_I_W'($signed({1'b0, gain_i_q})) * PROD_I_W'(error_sum_nxt);

	// bang-bang turn: steer and duty wheel follow the error sign
	logic                       err_pos;
	logic signed [STEER_W:0]    steer_sel;
	logic signed [TSV_W-1:0]    turn_servo;
	logic [ERR_W-1:0]           err_abs;
	logic                       turn_done;
	logic signed [DUTY_W-1:0]   left_nxt, right_nxt;
	logic                       done_nxt;
	assign err_pos    = (err > 0);
	assign steer_sel  = err_pos ? -(STEER_W+1)'(item_s1.turn_steer)
	                            : (STEER_W+1)'(item_s1.turn_steer);
	assign turn_servo = TSV_W'($signed({1'b0, mount_angle_q})) + TSV_W'(steer_sel);
	assign err_abs    = (err < 0) ? ERR_W'(-err) : ERR_W'(err);
	assign turn_done  = (err_abs < ERR_W'(angle_tolerance_q));
	always_comb begin
		if (movement_mode_q == MODE_PID) begin
			left_nxt  = item_s1.duty_offset;
			right_nxt = item_s1.duty_offset;
			done_nxt  = item_s1.stop_request;
		end else begin
			left_nxt  = err_pos ? item_s1.duty_offset : '0;
			right_nxt = err_pos ? '0 : item_s1.duty_offset;
			done_nxt  = turn_done;
		end
	end

	// state moves as an item leaves stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			error_sum_q      <= '0;
			previous_error_q <= '0;
			finished_q       <= 1'b0;
		end else if (step1) begin
			if (movement_mode_q == MODE_PID) begin
				error_sum_q      <= error_sum_nxt;
				previous_error_q <= err;
			end
			if (done_nxt) begin
				finished_q <= 1'b1;
			end
		end
	end

	// ---------------------------------------------------------------- stage 2
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (go1) begin
			valid_s2 <= valid_s1 && !finished_q;
		end
	end

	always_ff @(posedge clk) begin
		if (step1) begin
			mode_s2       <= movement_mode_q;
			prod_p_s2     <= prod_p;
			prod_d_s2     <= prod_d;
			prod_i_s2     <= prod_i;
			turn_servo_s2 <= turn_servo;
			left_s2       <= left_nxt;
			right_s2      <= right_nxt;
			done_s2       <= done_nxt;
		end
	end

	// correction in Q(frac+8) degrees, rounded half up to whole degrees
	logic signed [CORR_W-1:0] corr_sum, corr_biased;
	logic signed [RND_W-1:0]  corr_rnd;
	logic signed [SV_W-1:0]   mount_sv, servo_pid, drive_lo, drive_hi, drive_pid;
	logic signed [SV_W-1:0]   servo_raw, drive_raw;
	assign corr_sum    = CORR_W'(prod_p_s2) + CORR_W'(prod_d_s2) + CORR_W'(prod_i_s2);
	assign corr_biased = corr_sum + RND_HALF;
	assign corr_rnd    = $signed(corr_biased[CORR_W-1:RS]);
	assign mount_sv    = SV_W'($signed({1'b0, mount_angle_q}));
	assign servo_pid   = mount_sv - SV_W'(corr_rnd);
	assign drive_lo    = mount_sv - SV_W'($signed({1'b0, max_steer_q}));
	assign drive_hi    = mount_sv + SV_W'($signed({1'b0, max_steer_q}));
	always_comb begin
		if (servo_pid < drive_lo) begin
			drive_pid = drive_lo;
		end else if (servo_pid > drive_hi) begin
			drive_pid = drive_hi;
		end else begin
			drive_pid = servo_pid;
		end
	end
	assign servo_raw = (mode_s2 == MODE_PID) ? servo_pid : SV_W'(turn_servo_s2);
	assign drive_raw = (mode_s2 == MODE_PID) ? drive_pid : SV_W'(turn_servo_s2);

	// output saturation
	logic signed [SERVO_W-1:0] servo_sat;
	logic [DRIVE_W-1:0]        drive_sat;
	always_comb begin
		if (servo_raw < SERVO_MIN) begin
			servo_sat = SERVO_MIN[SERVO_W-1:0];
		end else if (servo_raw > SERVO_MAX) begin
			servo_sat = SERVO_MAX[SERVO_W-1:0];
		end else begin
			servo_sat = servo_raw[SERVO_W-1:0];
		end
		if (drive_raw < 0) begin
			drive_sat = '0;
		end else if (drive_raw > DRIVE_MAX) begin
			drive_sat = DRIVE_MAX[DRIVE_W-1:0];
		end else begin
			drive_sat = drive_raw[DRIVE_W-1:0];
		end
	end

	// ---------------------------------------------------------------- output
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (go2) begin
			out_valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (go2 && valid_s2) begin
			out_item_q.pad         <= '0;
			out_item_q.servo_cmd   <= servo_sat;
			out_item_q.drive_angle <= drive_sat;
			out_item_q.left_duty   <= left_s2;
			out_item_q.right_duty  <= right_s2;
			out_done_q             <= done_s2;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = OUT_TDATA_W'(out_item_q);
	assign m_tlast  = out_done_q;

`ifndef NO_ASSERTIONS
	// nothing enters the pipeline once the movement is finished
	a_no_item_after_done: assert property (@(posedge clk) disable iff (!arst_n)
		(finished_q && go1) |=> !valid_s2)
		else $error("item passed stage 1 after movement finished");

	// the accumulator never reaches the most negative code
	a_sum_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		error_sum_q != {1'b1, {(ES_W-1){1'b0}}})
		else $error("error sum outside clamp range");

	// a done result implies the finished flag is set
	a_done_sets_finished: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tlast) |-> finished_q)
		else $error("done result without finished flag");

	// turn mode leaves the pid state alone
	a_turn_keeps_state: assert property (@(posedge clk) disable iff (!arst_n)
		(step1 && movement_mode_q == MODE_TURN) |=>
			($stable(error_sum_q) && $stable(previous_error_q)))
		else $error("pid state changed in turn mode");
`endif

endmodule
